// ===== sv/wrr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the weighted round-robin picker.
// Used by wrr_ctrl, wrr_datapath and weighted_round_robin_picker; no dependencies.
package wrr_pkg;

  // Fixed widths of the item fields and the configuration port
  localparam int MAX_REQ        = 8;
  localparam int IDX_BITS       = 3;
  localparam int CNT_BITS       = 4;
  localparam int POS_BITS       = 4;
  localparam int FIELD_BITS     = 8;
  localparam int TRY_BITS       = 5;
  localparam int CFG_DATA_BITS  = 64;
  localparam int CFG_INDEX_BITS = 2;

  // Position value meaning "before the first requester"
  localparam logic [POS_BITS-1:0] POS_NONE = 4'd15;

  // Register reset values
  localparam logic [CFG_DATA_BITS-1:0] WEIGHTS_RESET = 64'h0101_0101_0101_0101;
  localparam logic [CNT_BITS-1:0]      COUNT_RESET   = 4'd8;

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WEIGHTS = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_COUNT   = 2'd1;

  typedef struct packed {
    logic [7:0]          runnable_mask;
    logic [IDX_BITS-1:0] current_index;
    logic                current_is_idle;
    logic [IDX_BITS-1:0] previous_index;
    logic                current_has_budget;
  } in_item_t;

  typedef struct packed {
    logic                granted;
    logic [IDX_BITS-1:0] grant_index;
  } out_item_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic derive_clear;
    logic derive_load;
    logic gcd_step;
    logic item_load;
    logic decide;
    logic walk_step;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic gcd_done;
    logic derive_last;
    logic fast_keep;
    logic sum_zero;
    logic walk_done;
  } status_t;

endpackage

// ===== sv/weighted_round_robin_picker.sv =====
`timescale 1ns / 1ps
// Interleaved weighted round-robin picker, top level.
// Depends on wrr_pkg, wrr_ctrl and wrr_datapath.
//
// Usage:
//   Decision requests enter on in_valid/in_ready with an in_item; one result
//   per request leaves on out_valid/out_ready as an out_item (granted, index).
//   The user writes weights and the requester count through cfg_we/cfg_index/
//   cfg_data only while no request is in flight; the block has no check.
// Request flow:
//   For a kept requester, or all weights zero, DECIDE goes straight to FINISH,
//   which loads the result and raises out_valid. Otherwise the walk visits one
//   position per cycle and gives up after 2*count+1 positions without a hit.
//   The next request is accepted the cycle after the result is registered,
//   even while it waits at the output; a new request waits until then.
// Reset and configuration:
//   After reset, and after any write to the weights or count register, max, gcd
//   and sum are derived again: per requester a load step, then subtraction
//   steps of the gcd at one step per cycle; in_ready stays low meanwhile.
// Stalls: while out_ready is low the result holds in the output register
//   and a further finished result waits inside the block.
module weighted_round_robin_picker #(
  parameter int REQUESTERS  = 8,
  parameter int WEIGHT_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  wrr_pkg::in_item_t                  in_item,
  output logic                               out_valid,
  input  logic                               out_ready,
  output wrr_pkg::out_item_t                 out_item,
  input  logic                               cfg_we,
  input  logic [wrr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [wrr_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  wrr_pkg::cmd_t    cmd;
  wrr_pkg::status_t status;

  wrr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .status    (status),
    .cmd       (cmd)
  );

  wrr_datapath #(
    .REQUESTERS  (REQUESTERS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_item  (out_item)
  );

`ifndef NO_ASSERTIONS
  // Commands are mutually exclusive
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.derive_clear, cmd.derive_load, cmd.gcd_step, cmd.item_load,
              cmd.decide, cmd.walk_step, cmd.out_load}))
    else $error("controller issued more than one command");

  // An accepted item is decided in the next cycle
  a_accept_decide: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !cfg_we |=> cmd.decide)
    else $error("accepted item not decided");

  // A result is loaded only into a free or draining output register
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result overwrote a pending item");

  // An idle result carries index zero
  a_idle_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.granted |-> out_item.grant_index == '0)
    else $error("idle result with nonzero index");
`endif

endmodule

// ===== sv/wrr_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the weighted round-robin picker: sequences derivation, decision and walk.
// Depends on wrr_pkg for the command and status structs.
module wrr_ctrl (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  output logic                               out_valid,
  input  logic                               out_ready,
  input  logic                               cfg_we,
  input  logic [wrr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wrr_pkg::status_t                   status,
  output wrr_pkg::cmd_t                      cmd
);

  typedef enum logic [2:0] {
    S_DCLEAR,
    S_DLOAD,
    S_DGCD,
    S_IDLE,
    S_DECIDE,
    S_WALK,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   cfg_hit;

  assign cfg_hit  = cfg_we && (cfg_index == wrr_pkg::CFG_WEIGHTS ||
                               cfg_index == wrr_pkg::CFG_COUNT);
  assign in_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_DCLEAR: begin
        cmd.derive_clear = 1'b1;
        state_next       = S_DLOAD;
      end
      S_DLOAD: begin
        cmd.derive_load = 1'b1;
        state_next      = S_DGCD;
      end
      S_DGCD: begin
        cmd.gcd_step = 1'b1;
        if (status.gcd_done) begin
          state_next = status.derive_last ? S_IDLE : S_DLOAD;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.item_load = 1'b1;
          state_next    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = (status.fast_keep || status.sum_zero) ? S_FINISH : S_WALK;
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (status.walk_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_DCLEAR;
    endcase
    // A write to the weights or count register restarts the derivation of max, gcd and sum
    if (cfg_hit) begin
      state_next = S_DCLEAR;
    end
  end

  // Hold state and the output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_DCLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/wrr_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the weighted round-robin picker: registers, weight derivation and walk step.
// Depends on wrr_pkg; driven by the commands of wrr_ctrl.
module wrr_datapath #(
  parameter int REQUESTERS  = 8,
  parameter int WEIGHT_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [wrr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [wrr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  wrr_pkg::in_item_t                  in_item,
  input  wrr_pkg::cmd_t                      cmd,
  output wrr_pkg::status_t                   status,
  output wrr_pkg::out_item_t                 out_item
);

  localparam int SUM_BITS = WEIGHT_BITS + $clog2(REQUESTERS);

  // Configuration and walk state
  logic [wrr_pkg::CFG_DATA_BITS-1:0] weights;
  logic [wrr_pkg::CNT_BITS-1:0]      req_count;
  logic [wrr_pkg::POS_BITS-1:0]      position;
  logic [WEIGHT_BITS-1:0]            cur_weight;
  logic [SUM_BITS-1:0]               served_count;

  // Derived values and gcd working pair
  logic [wrr_pkg::IDX_BITS-1:0] dk;
  logic [WEIGHT_BITS-1:0]       wmax;
  logic [WEIGHT_BITS-1:0]       gcd_val;
  logic [SUM_BITS-1:0]          sum;
  logic [WEIGHT_BITS-1:0]       ga;
  logic [WEIGHT_BITS-1:0]       gb;

  // Per-item registers
  wrr_pkg::in_item_t            item;
  wrr_pkg::out_item_t           res;
  logic [SUM_BITS-1:0]          sel;
  logic [wrr_pkg::TRY_BITS-1:0] tries;

  logic [wrr_pkg::CNT_BITS-1:0] n;
  logic [WEIGHT_BITS-1:0]       wt [wrr_pkg::MAX_REQ];
  logic [WEIGHT_BITS-1:0]       wd;
  logic [wrr_pkg::IDX_BITS-1:0] from_idx;
  logic [wrr_pkg::POS_BITS-1:0] p_inc;
  logic [wrr_pkg::POS_BITS-1:0] p;
  logic [WEIGHT_BITS-1:0]       cw_dec;
  logic [WEIGHT_BITS-1:0]       cw_new;
  logic [WEIGHT_BITS-1:0]       wp;
  logic                         hit;
  logic                         runnable;
  logic                         back_home;
  logic [SUM_BITS-1:0]          served_inc;
  logic                         cycle_end;
  logic [SUM_BITS-1:0]          sel_inc;
  logic                         sel_last;
  logic [wrr_pkg::TRY_BITS-1:0] tries_inc;
  logic                         tries_last;

  // Clamp the requester count to 1..REQUESTERS
  always_comb begin
    if (req_count == '0) begin
      n = 4'd1;
    end else if (req_count > wrr_pkg::CNT_BITS'(REQUESTERS)) begin
      n = wrr_pkg::CNT_BITS'(REQUESTERS);
    end else begin
      n = req_count;
    end
  end

  // Unpack weights; requesters not taking part read as zero
  always_comb begin
    for (int k = 0; k < wrr_pkg::MAX_REQ; k++) begin
      if (k < REQUESTERS && wrr_pkg::CNT_BITS'(k) < n) begin
        wt[k] = weights[wrr_pkg::FIELD_BITS*k +: WEIGHT_BITS];
      end else begin
        wt[k] = '0;
      end
    end
  end

  assign wd = wt[dk];

  // Subtractive gcd finishes when either side is zero or both agree
  assign status.gcd_done    = (gb == '0) || (ga == '0) || (ga == gb);
  assign status.derive_last = (dk == wrr_pkg::IDX_BITS'(REQUESTERS - 1));
  assign status.sum_zero    = (sum == '0);
  assign status.fast_keep   = !item.current_is_idle &&
                              ({1'b0, item.current_index} < n) &&
                              item.runnable_mask[item.current_index] &&
                              item.current_has_budget &&
                              (wt[item.current_index] != '0);

  // One position of the interleaved walk
  assign from_idx   = item.current_is_idle ? item.previous_index : item.current_index;
  assign p_inc      = (position >= n) ? '0 : position + 4'd1;
  assign p          = (p_inc >= n) ? '0 : p_inc;
  assign cw_dec     = (cur_weight <= gcd_val) ? wmax : cur_weight - gcd_val;
  assign cw_new     = (p == '0) ? cw_dec : cur_weight;
  assign wp         = wt[p[wrr_pkg::IDX_BITS-1:0]];
  assign hit        = (wp != '0) && (wp >= cw_new);
  assign runnable   = item.runnable_mask[p[wrr_pkg::IDX_BITS-1:0]];
  assign back_home  = (p[wrr_pkg::IDX_BITS-1:0] == from_idx);
  assign served_inc = served_count + 1'b1;
  assign cycle_end  = (served_inc >= sum);
  assign sel_inc    = sel + 1'b1;
  assign sel_last   = (sel_inc == sum);
  assign tries_inc  = tries + 1'b1;
  assign tries_last = (tries_inc == {n, 1'b1});

  assign status.walk_done = hit ? (runnable || back_home || sel_last) : tries_last;

  // Configuration registers and walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      weights      <= wrr_pkg::WEIGHTS_RESET;
      req_count    <= wrr_pkg::COUNT_RESET;
      position     <= wrr_pkg::POS_NONE;
      cur_weight   <= '0;
      served_count <= '0;
    end else begin
      if (cmd.walk_step) begin
        if (hit && cycle_end) begin
          position     <= wrr_pkg::POS_NONE;
          cur_weight   <= '0;
          served_count <= '0;
        end else begin
          position   <= p;
          cur_weight <= cw_new;
          if (hit) begin
            served_count <= served_inc;
          end
        end
      end
      if (cfg_we) begin
        unique case (cfg_index)
          wrr_pkg::CFG_WEIGHTS: begin
            weights      <= cfg_data;
            position     <= wrr_pkg::POS_NONE;
            cur_weight   <= '0;
            served_count <= '0;
          end
          wrr_pkg::CFG_COUNT: begin
            req_count    <= cfg_data[wrr_pkg::CNT_BITS-1:0];
            position     <= wrr_pkg::POS_NONE;
            cur_weight   <= '0;
            served_count <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // Derivation, item and result registers
  always_ff @(posedge clk) begin
    if (cmd.derive_clear) begin
      dk      <= '0;
      wmax    <= '0;
      gcd_val <= '0;
      sum     <= '0;
    end
    if (cmd.derive_load) begin
      if (wd > wmax) begin
        wmax <= wd;
      end
      sum <= sum + SUM_BITS'(wd);
      ga  <= gcd_val;
      gb  <= wd;
    end
    if (cmd.gcd_step) begin
      if (status.gcd_done) begin
        gcd_val <= (ga == '0) ? gb : ga;
        dk      <= dk + 1'b1;
      end else if (ga > gb) begin
        ga <= ga - gb;
      end else begin
        gb <= gb - ga;
      end
    end
    if (cmd.item_load) begin
      item <= in_item;
    end
    if (cmd.decide) begin
      sel   <= '0;
      tries <= '0;
      if (status.fast_keep) begin
        res <= '{granted: 1'b1, grant_index: item.current_index};
      end else begin
        res <= '0;
      end
    end
    if (cmd.walk_step) begin
      if (hit) begin
        sel   <= sel_inc;
        tries <= '0;
      end else begin
        tries <= tries_inc;
      end
      if (hit && runnable) begin
        res <= '{granted: 1'b1, grant_index: p[wrr_pkg::IDX_BITS-1:0]};
      end else begin
        res <= '0;
      end
    end
    if (cmd.out_load) begin
      out_item <= res;
    end
  end

endmodule
